// ===== sv/scara_ik_pkg.sv =====
// Shared types, widths and constants of the SCARA inverse kinematics pipeline.
// Used by scara_ik_cordic, scara_ik_acos and the top level; no dependencies.
package scara_ik_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BASE_LENGTH      = 3'd0,
        CFG_UPPER_ARM_LENGTH = 3'd1,
        CFG_FOREARM_LENGTH   = 3'd2,
        CFG_FOREARM_OFFSET   = 3'd3,
        CFG_TOOL_Z_OFFSET    = 3'd4,
        CFG_GEAR_RATIO       = 3'd5,
        CFG_ROTARY_LIMITS    = 3'd6,
        CFG_LINEAR_LIMITS    = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_VALID       = 2'd0,
        ST_UNREACHABLE = 2'd1,
        ST_LIMIT       = 2'd2
    } t_status;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // Angles in radians times 65536.
    localparam int ANG_W        = 20;
    localparam int HALF_PI_Q16  = 102944;
    localparam int DEG_SCALE    = 3754936;

    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 1;
    localparam logic [15:0] ATAN_TAB [CORDIC_ITERS] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
    };

    // Cosine ratio: numerator, divisor, normalized divisor and quotient widths.
    localparam int NUM_W        = 53;
    localparam int DEN_W        = 51;
    localparam int DIV_W        = 46;
    localparam int Q_W          = 17;
    localparam int S2_W         = 34;
    localparam int ACOS_CORDIC_W = 20;
    localparam int ACOS_LAT     = 1 + Q_W + 2 + S2_W / 2 + CORDIC_LAT;

    // Range squared and the vector CORDIC used for the target bearing.
    localparam int R2_W         = 52;
    localparam int GAMMA_W      = 28;

    typedef struct packed {
        logic                    ok;
        logic signed [ANG_W-1:0] ang;
    } t_acos_res;

    typedef struct packed {
        logic signed [31:0] joint_one;
        logic signed [31:0] joint_two;
        logic signed [31:0] joint_three;
        t_status            status;
        logic               alt_elbow;
    } t_result;

endpackage

// ===== sv/scara_ik_delay.sv =====
// Enabled shift register that carries side data alongside the pipeline.
// No dependencies.
module scara_ik_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[D-1];

endmodule

// ===== sv/scara_ik_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// No dependencies.
module scara_ik_isqrt #(
    parameter int IN_W = 52
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_val,
    output logic [IN_W/2-1:0] o_root
);

    localparam int STAGES = IN_W / 2;

    logic [IN_W:0] r_v [STAGES];
    logic [IN_W:0] r_r [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam logic [IN_W:0] BIT = (IN_W + 1)'(1) << (IN_W - 2 - 2 * s);
        logic [IN_W:0] v_in, r_in, trial, n_v, n_r;

        if (s == 0) begin : g_first
            assign v_in = {1'b0, i_val};
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[s-1];
            assign r_in = r_r[s-1];
        end

        assign trial = r_in + BIT;

        always_comb begin
            if (v_in >= trial) begin
                n_v = v_in - trial;
                n_r = (r_in >> 1) + BIT;
            end else begin
                n_v = v_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[s] <= n_v;
                r_r[s] <= n_r;
            end
        end
    end

    assign o_root = r_r[STAGES-1][IN_W/2-1:0];

endmodule

// ===== sv/scara_ik_cordic.sv =====
// Vectoring CORDIC for atan2, a quadrant fold then one rotation per stage.
// Depends on scara_ik_pkg for the arctangent table and iteration count.
module scara_ik_cordic #(
    parameter int W   = 28,
    parameter int Z_W = 20
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    output logic signed [Z_W-1:0] o_z
);

    localparam int N = scara_ik_pkg::CORDIC_ITERS;
    localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(scara_ik_pkg::HALF_PI_Q16);

    logic signed [W-1:0]   r_x [N+1];
    logic signed [W-1:0]   r_y [N+1];
    logic signed [Z_W-1:0] r_z [N+1];

    logic signed [W-1:0]   n_x0, n_y0;
    logic signed [Z_W-1:0] n_z0;

    // Fold a left half-plane vector by a quarter turn.
    always_comb begin
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI;
            end
        end else begin
            n_x0 = i_x;
            n_y0 = i_y;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [Z_W-1:0] ANG = Z_W'(scara_ik_pkg::ATAN_TAB[i]);
        logic signed [W-1:0] ddx, ddy;

        assign ddx = r_y[i] >>> i;
        assign ddy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ddx;
                    r_y[i+1] <= r_y[i] - ddy;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - ddx;
                    r_y[i+1] <= r_y[i] + ddy;
                    r_z[i+1] <= r_z[i] - ANG;
                end
            end
        end
    end

    assign o_z = r_z[N];

endmodule

// ===== sv/scara_ik_acos.sv =====
// Cosine ratio and arc cosine: normalize, restoring divide, sine by square
// root, then atan2. Depends on scara_ik_pkg, scara_ik_delay, scara_ik_isqrt
// and scara_ik_cordic.
module scara_ik_acos #(
    parameter int NUM_W = scara_ik_pkg::NUM_W,
    parameter int DEN_W = scara_ik_pkg::DEN_W
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output scara_ik_pkg::t_acos_res o_res
);

    localparam int DIV_W = scara_ik_pkg::DIV_W;
    localparam int Q_W   = scara_ik_pkg::Q_W;
    localparam int S2_W  = scara_ik_pkg::S2_W;
    localparam int RT_W  = S2_W / 2;
    localparam int CW    = scara_ik_pkg::ACOS_CORDIC_W;
    localparam int ANG_W = scara_ik_pkg::ANG_W;
    localparam int OK_DLY = scara_ik_pkg::ACOS_LAT - 1;
    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);
    localparam logic [S2_W-1:0] ONE_SQ = S2_W'(1) << 32;

    // Normalize: drop low bits of both operands until the divisor fits DIV_W.
    logic [NUM_W-1:0] mag, m_full;
    logic [DEN_W-1:0] d_full;
    logic             n_ok;
    logic [DIV_W-1:0] r_p_m, r_p_d;
    logic             r_p_neg, r_p_ok;

    always_comb begin
        int k;
        k = 0;
        for (int p = DIV_W; p < DEN_W; p++) begin
            if (i_den[p]) begin
                k = p - DIV_W + 1;
            end
        end
        mag    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_ok   = (i_den != '0) && (mag <= NUM_W'(i_den));
        m_full = mag >> k;
        d_full = i_den >> k;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_m   <= m_full[DIV_W-1:0];
            r_p_d   <= d_full[DIV_W-1:0];
            r_p_neg <= i_num[NUM_W-1];
            r_p_ok  <= n_ok;
        end
    end

    // Restoring divide of m * 65536 by d, one quotient bit per stage.
    logic [DIV_W:0]   r_rem [Q_W];
    logic [DIV_W-1:0] r_d   [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic             r_neg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [DIV_W:0]   rem_in;
        logic [DIV_W-1:0] d_in;
        logic [Q_W-1:0]   q_in;
        logic             neg_in, ge;

        if (j == 0) begin : g_first
            assign rem_in = {1'b0, r_p_m};
            assign d_in   = r_p_d;
            assign q_in   = '0;
            assign neg_in = r_p_neg;
        end else begin : g_next
            assign rem_in = {r_rem[j-1][DIV_W-1:0], 1'b0};
            assign d_in   = r_d[j-1];
            assign q_in   = r_q[j-1];
            assign neg_in = r_neg[j-1];
        end

        assign ge = rem_in >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? rem_in - {1'b0, d_in} : rem_in;
                r_d[j]   <= d_in;
                r_q[j]   <= {q_in[Q_W-2:0], ge};
                r_neg[j] <= neg_in;
            end
        end
    end

    // Signed cosine, then one minus its square.
    logic [Q_W-1:0]          q_clamp;
    logic signed [Q_W:0]     r_c, r_c2;
    logic signed [2*Q_W+1:0] cc;
    logic [S2_W-1:0]         r_s2;

    assign q_clamp = (r_q[Q_W-1] > ONE_Q16) ? ONE_Q16 : r_q[Q_W-1];
    assign cc      = r_c * r_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= r_neg[Q_W-1] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
            r_s2 <= ONE_SQ - S2_W'(cc);
            r_c2 <= r_c;
        end
    end

    logic [RT_W-1:0]     root;
    logic [Q_W:0]        c_dly;
    logic signed [ANG_W-1:0] z;
    logic                ok_dly;

    scara_ik_isqrt #(.IN_W(S2_W)) u_sine (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (r_s2),
        .o_root (root)
    );

    scara_ik_delay #(.W(Q_W + 1), .D(RT_W)) u_cos_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_c2),
        .o_q   (c_dly)
    );

    scara_ik_cordic #(.W(CW), .Z_W(ANG_W)) u_atan (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (CW'($signed(c_dly))),
        .i_y   ($signed({{(CW - RT_W){1'b0}}, root})),
        .o_z   (z)
    );

    scara_ik_delay #(.W(1), .D(OK_DLY)) u_ok_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_p_ok),
        .o_q   (ok_dly)
    );

    assign o_res.ok  = ok_dly;
    assign o_res.ang = ok_dly ? z : '0;

endmodule

// ===== sv/scara_rrp_inverse_kinematics.sv =====
// Top level of the SCARA (rotary-rotary-prismatic) inverse kinematics pipeline.
// Depends on scara_ik_pkg, scara_ik_delay, scara_ik_isqrt, scara_ik_cordic
// and scara_ik_acos.
//
//  channel | dir | handshake          | words
//  s_axis  | in  | tvalid / tready    | tdata: target_x, target_y, target_z
//  m_axis  | out | tvalid / tready    | tdata: joint angles; tuser: status, alt elbow
//  cfg     | in  | we, no back-pressure | index, data
//
// One word enters per cycle while the skid slot is empty. The path runs through the
// 26-step range square root followed by the arc cosine chain (17-step divider,
// 17-step square root, 17-stage CORDIC), which both cosine ratios run side by side.
// Reset is synchronous and clears the valid bits, the output and skid valid flags and the configuration registers.
// A stalled output fills one skid slot; while it is full the whole pipeline holds.
module scara_rrp_inverse_kinematics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [71:0]  i_s_axis_tdata,   // target_x, target_y, target_z
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // joint_one, joint_two, joint_three angles
    output logic [2:0]   o_m_axis_tuser,   // status, alternate_elbow
    input  logic         i_cfg_we,
    input  logic [scara_ik_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [scara_ik_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int R2_W      = scara_ik_pkg::R2_W;
    localparam int RT_W      = R2_W / 2;
    localparam int NUM_W     = scara_ik_pkg::NUM_W;
    localparam int DEN_W     = scara_ik_pkg::DEN_W;
    localparam int ANG_W     = scara_ik_pkg::ANG_W;
    localparam int GW        = scara_ik_pkg::GAMMA_W;
    localparam int S_ROOT    = 3 + RT_W;
    localparam int S_ACOS_IN = S_ROOT + 1;
    localparam int S_JOIN    = S_ACOS_IN + scara_ik_pkg::ACOS_LAT;
    localparam int LAT       = S_JOIN + 4;
    localparam int GAMMA_DLY = S_JOIN - (1 + scara_ik_pkg::CORDIC_LAT);
    localparam int NUM_DLY   = S_ACOS_IN - 4;
    localparam int LIN_DLY   = S_JOIN - 4;

    // Configuration registers.
    logic [23:0]        r_cfg_base, r_cfg_upper, r_cfg_fore;
    logic signed [17:0] r_cfg_beta;
    logic signed [23:0] r_cfg_tzo;
    logic [15:0]        r_cfg_gear;
    logic [63:0]        r_cfg_rot, r_cfg_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_upper <= '0;
            r_cfg_fore  <= '0;
            r_cfg_beta  <= '0;
            r_cfg_tzo   <= '0;
            r_cfg_gear  <= '0;
            r_cfg_rot   <= '0;
            r_cfg_lin   <= '0;
        end else if (i_cfg_we) begin
            unique case (scara_ik_pkg::t_cfg_index'(i_cfg_index))
                scara_ik_pkg::CFG_BASE_LENGTH:      r_cfg_base  <= i_cfg_data[23:0];
                scara_ik_pkg::CFG_UPPER_ARM_LENGTH: r_cfg_upper <= i_cfg_data[23:0];
                scara_ik_pkg::CFG_FOREARM_LENGTH:   r_cfg_fore  <= i_cfg_data[23:0];
                scara_ik_pkg::CFG_FOREARM_OFFSET:   r_cfg_beta  <= i_cfg_data[17:0];
                scara_ik_pkg::CFG_TOOL_Z_OFFSET:    r_cfg_tzo   <= i_cfg_data[23:0];
                scara_ik_pkg::CFG_GEAR_RATIO:       r_cfg_gear  <= i_cfg_data[15:0];
                scara_ik_pkg::CFG_ROTARY_LIMITS:    r_cfg_rot   <= i_cfg_data;
                scara_ik_pkg::CFG_LINEAR_LIMITS:    r_cfg_lin   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: the pipeline moves while the skid slot is free.
    logic                  adv, in_fire;
    logic [LAT-1:0]        r_valid;
    scara_ik_pkg::t_result r_out, r_skid, n_result;
    logic                  r_out_vld, r_skid_vld;

    assign adv             = !r_skid_vld;
    assign o_s_axis_tready = adv;
    assign in_fire         = i_s_axis_tvalid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[LAT-2:0], in_fire};
        end
    end

    // Stage 1: offsets.
    logic signed [25:0] r_s1_dx;
    logic signed [23:0] r_s1_dy;
    logic signed [24:0] r_s1_nz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_dx <= 26'($signed(i_s_axis_tdata[23:0])) - $signed({2'b00, r_cfg_base});
            r_s1_dy <= $signed(i_s_axis_tdata[47:24]);
            r_s1_nz <= 25'(r_cfg_tzo) - 25'($signed(i_s_axis_tdata[71:48]));
        end
    end

    // Stage 2: squares and link products.
    logic signed [51:0] p_dx2;
    logic signed [47:0] p_dy2;
    logic signed [41:0] p_lin;
    logic [49:0]        r_s2_dx2;
    logic [46:0]        r_s2_dy2;
    logic [47:0]        r_s2_b2, r_s2_c2, r_s2_bc;
    logic signed [41:0] r_s2_prod;

    assign p_dx2 = r_s1_dx * r_s1_dx;
    assign p_dy2 = r_s1_dy * r_s1_dy;
    assign p_lin = r_s1_nz * $signed({1'b0, r_cfg_gear});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_dx2  <= p_dx2[49:0];
            r_s2_dy2  <= p_dy2[46:0];
            r_s2_b2   <= r_cfg_upper * r_cfg_upper;
            r_s2_c2   <= r_cfg_fore * r_cfg_fore;
            r_s2_bc   <= r_cfg_upper * r_cfg_fore;
            r_s2_prod <= p_lin;
        end
    end

    // Stage 3: range squared, link sums, rounded and saturated linear axis angle.
    logic [R2_W-2:0]    r_s3_r2;
    logic [48:0]        r_s3_bpc, r_s3_den2;
    logic signed [48:0] r_s3_bmc;
    logic signed [31:0] r_s3_ang3, n_ang3;
    logic signed [41:0] lin_sh;

    assign lin_sh = (r_s2_prod + 42'sd128) >>> 8;

    always_comb begin
        if (lin_sh > 42'sd2147483647) begin
            n_ang3 = 32'sh7fffffff;
        end else if (lin_sh < -42'sd2147483648) begin
            n_ang3 = 32'sh80000000;
        end else begin
            n_ang3 = lin_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_r2   <= (R2_W - 1)'(r_s2_dx2) + (R2_W - 1)'(r_s2_dy2);
            r_s3_bpc  <= 49'(r_s2_b2) + 49'(r_s2_c2);
            r_s3_bmc  <= $signed({1'b0, r_s2_b2}) - $signed({1'b0, r_s2_c2});
            r_s3_den2 <= {r_s2_bc, 1'b0};
            r_s3_ang3 <= n_ang3;
        end
    end

    // Stage 4: cosine numerators, linear limit check.
    logic signed [NUM_W-1:0] r_s4_num1, r_s4_num2;
    logic [DEN_W-1:0]        r_s4_den2;
    logic signed [31:0]      r_s4_ang3;
    logic                    r_s4_bad3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_num2 <= $signed({2'b00, r_s3_r2}) - $signed({4'b0000, r_s3_bpc});
            r_s4_num1 <= $signed({2'b00, r_s3_r2}) + NUM_W'(r_s3_bmc);
            r_s4_den2 <= DEN_W'(r_s3_den2);
            r_s4_ang3 <= r_s3_ang3;
            r_s4_bad3 <= (r_s3_ang3 < $signed(r_cfg_lin[31:0]))
                      || (r_s3_ang3 > $signed(r_cfg_lin[63:32]));
        end
    end

    // Range, then the divisor of the shoulder cosine.
    logic [RT_W-1:0]  root;
    logic [DEN_W-1:0] r_s30_den1;

    scara_ik_isqrt #(.IN_W(R2_W)) u_range (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  ({1'b0, r_s3_r2}),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s30_den1 <= {(DEN_W - 1)'(r_cfg_upper * root), 1'b0};
        end
    end

    logic [NUM_W-1:0] num1_dly, num2_dly;
    logic [DEN_W-1:0] den2_dly;

    scara_ik_delay #(.W(NUM_W), .D(NUM_DLY)) u_num1_dly (
        .i_clk (i_clk), .i_en (adv), .i_d (r_s4_num1), .o_q (num1_dly)
    );

    scara_ik_delay #(.W(NUM_W), .D(NUM_DLY)) u_num2_dly (
        .i_clk (i_clk), .i_en (adv), .i_d (r_s4_num2), .o_q (num2_dly)
    );

    scara_ik_delay #(.W(DEN_W), .D(NUM_DLY)) u_den2_dly (
        .i_clk (i_clk), .i_en (adv), .i_d (r_s4_den2), .o_q (den2_dly)
    );

    scara_ik_pkg::t_acos_res alpha_res, elbow_res;

    scara_ik_acos #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_alpha (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ($signed(num1_dly)),
        .i_den (r_s30_den1),
        .o_res (alpha_res)
    );

    scara_ik_acos #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_elbow (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ($signed(num2_dly)),
        .i_den (den2_dly),
        .o_res (elbow_res)
    );

    // Target bearing.
    logic signed [ANG_W-1:0] gamma;
    logic [ANG_W-1:0]        gamma_dly;

    scara_ik_cordic #(.W(GW), .Z_W(ANG_W)) u_bearing (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (GW'(r_s1_dx)),
        .i_y   (GW'(r_s1_dy)),
        .o_z   (gamma)
    );

    scara_ik_delay #(.W(ANG_W), .D(GAMMA_DLY)) u_gamma_dly (
        .i_clk (i_clk), .i_en (adv), .i_d (gamma), .o_q (gamma_dly)
    );

    logic [32:0] lin_dly;

    scara_ik_delay #(.W(33), .D(LIN_DLY)) u_lin_dly (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_s4_bad3, r_s4_ang3}), .o_q (lin_dly)
    );

    // Join stage: both elbow configurations in radians.
    logic signed [21:0] r_j_f0, r_j_f1, r_j_a0, r_j_a1;
    logic               r_j_ok0, r_j_ok1, r_j_bad3;
    logic signed [31:0] r_j_ang3;
    logic signed [21:0] ga, al, el, be;

    assign ga = 22'($signed(gamma_dly));
    assign al = 22'(alpha_res.ang);
    assign el = 22'(elbow_res.ang);
    assign be = 22'(r_cfg_beta);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_j_f0   <= -(ga + al);
            r_j_f1   <= -el - be;
            r_j_a0   <= al - ga;
            r_j_a1   <= el - be;
            r_j_ok0  <= alpha_res.ok;
            r_j_ok1  <= elbow_res.ok;
            r_j_ang3 <= $signed(lin_dly[31:0]);
            r_j_bad3 <= lin_dly[32];
        end
    end

    // Radians to 1/256 degree, rounded to the nearest step, ties toward plus infinity.
    function automatic logic signed [21:0] to_deg(input logic signed [21:0] rad);
        logic signed [46:0] p;
        p = 47'(rad) * 47'(scara_ik_pkg::DEG_SCALE);
        p = p + 47'sd8388608;
        return 22'(p >>> 24);
    endfunction

    function automatic logic rot_out(input logic signed [21:0] deg,
                                     input logic [15:0] lo_bits,
                                     input logic [15:0] hi_bits);
        logic signed [31:0] a, l, h;
        a = 32'(deg) * 32'sd100;
        l = 32'($signed(lo_bits)) * 32'sd256;
        h = 32'($signed(hi_bits)) * 32'sd256;
        return (a < l) || (a > h);
    endfunction

    logic signed [21:0] r_d_f0, r_d_f1, r_d_a0, r_d_a1;
    logic               r_d_ok0, r_d_ok1, r_d_bad3;
    logic signed [31:0] r_d_ang3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_f0   <= to_deg(r_j_f0);
            r_d_f1   <= to_deg(r_j_f1);
            r_d_a0   <= to_deg(r_j_a0);
            r_d_a1   <= to_deg(r_j_a1);
            r_d_ok0  <= r_j_ok0;
            r_d_ok1  <= r_j_ok1;
            r_d_ang3 <= r_j_ang3;
            r_d_bad3 <= r_j_bad3;
        end
    end

    // Rotary limit checks for both configurations.
    logic signed [21:0] r_l_f0, r_l_f1, r_l_a0, r_l_a1;
    logic               r_l_of0, r_l_of1, r_l_oa0, r_l_oa1;
    logic               r_l_ok0, r_l_ok1, r_l_bad3;
    logic signed [31:0] r_l_ang3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l_f0   <= r_d_f0;
            r_l_f1   <= r_d_f1;
            r_l_a0   <= r_d_a0;
            r_l_a1   <= r_d_a1;
            r_l_of0  <= rot_out(r_d_f0, r_cfg_rot[15:0], r_cfg_rot[31:16]);
            r_l_of1  <= rot_out(r_d_f1, r_cfg_rot[47:32], r_cfg_rot[63:48]);
            r_l_oa0  <= rot_out(r_d_a0, r_cfg_rot[15:0], r_cfg_rot[31:16]);
            r_l_oa1  <= rot_out(r_d_a1, r_cfg_rot[47:32], r_cfg_rot[63:48]);
            r_l_ok0  <= r_d_ok0;
            r_l_ok1  <= r_d_ok1;
            r_l_ang3 <= r_d_ang3;
            r_l_bad3 <= r_d_bad3;
        end
    end

    // Configuration choice and status.
    logic               alt, bad0, bad1;
    logic signed [21:0] sel0, sel1;
    scara_ik_pkg::t_status st;
    scara_ik_pkg::t_result r_res;

    always_comb begin
        alt  = (r_l_ok0 && r_l_of0) || (r_l_ok1 && r_l_of1);
        sel0 = alt ? r_l_a0 : r_l_f0;
        sel1 = alt ? r_l_a1 : r_l_f1;
        bad0 = alt ? r_l_oa0 : r_l_of0;
        bad1 = alt ? r_l_oa1 : r_l_of1;
        priority if (!r_l_ok0) begin
            st = scara_ik_pkg::ST_UNREACHABLE;
        end else if (bad0) begin
            st = scara_ik_pkg::ST_LIMIT;
        end else if (!r_l_ok1) begin
            st = scara_ik_pkg::ST_UNREACHABLE;
        end else if (bad1 || r_l_bad3) begin
            st = scara_ik_pkg::ST_LIMIT;
        end else begin
            st = scara_ik_pkg::ST_VALID;
        end
        n_result.joint_one   = r_l_ok0 ? 32'(sel0) : '0;
        n_result.joint_two   = r_l_ok1 ? 32'(sel1) : '0;
        n_result.joint_three = r_l_ang3;
        n_result.status      = st;
        n_result.alt_elbow   = alt;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_result;
        end
    end

    // Output register with one skid slot.
    logic take, pipe_vld;

    assign pipe_vld = r_valid[LAT-1];
    assign take     = r_out_vld && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= pipe_vld;
            end
        end else if (pipe_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_vld) begin
            r_out <= r_skid_vld ? r_skid : r_res;
        end else if (adv && pipe_vld) begin
            r_skid <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out.joint_three, r_out.joint_two, r_out.joint_one};
    assign o_m_axis_tuser  = {r_out.alt_elbow, r_out.status};

    // The skid slot only fills behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot holds a word while the output register is empty");

    // A finished word held by a stall is still there on the next cycle.
    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_vld && !adv) |=> pipe_vld)
        else $error("pipeline dropped a finished word during a stall");

    // An unreachable result carries a zeroed rotary angle.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1:0] == scara_ik_pkg::ST_UNREACHABLE)
        |-> (o_m_axis_tdata[31:0] == '0 || o_m_axis_tdata[63:32] == '0))
        else $error("unreachable status without a zeroed joint angle");

endmodule
